// ----- hw/rtl/tlbc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbc_pkg: shared types and constants for the four-word block cipher
// Holds the block and key types, the word-update step codes and the per-round
// sum constant.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbc_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned KEY_WORDS  = 8;
	localparam int unsigned KEY_IDX_W  = 3;
	localparam int unsigned STEPS_PER_ROUND = 4;

	localparam logic [WORD_W-1:0] ROUND_DELTA = 32'h9e37_79b9;

	typedef logic [WORD_W-1:0] word_t;

	// One 128-bit block as four words
	typedef struct packed {
		word_t w0;
		word_t w1;
		word_t w2;
		word_t w3;
	} block_t;

	// Eight key words, element i is key word i
	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	// Which word a pipeline stage updates, in round order
	typedef enum logic [1:0] {
		STEP_W2 = 2'd0,
		STEP_W3 = 2'd1,
		STEP_W0 = 2'd2,
		STEP_W1 = 2'd3
	} step_t;

	// Running sum after round rnd (counting from zero), wraps mod 2^32
	function automatic word_t round_sum(input int unsigned rnd);
		word_t acc;
		acc = word_t'(rnd + 1) * ROUND_DELTA;
		return acc;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tea_like_block_cipher_128.sv -----
// ----------------------------------------------------------------------------
// tea_like_block_cipher_128: pipelined four-word block cipher, 256-bit key
//
//   port group     dir  width      meaning
//   start/busy     in   1/1(out)   request strobe; busy is always low
//   plain_word_*   in   4 x 32     plaintext block, taken with start
//   done           out  1          result strobe, one cycle per block
//   cipher_word_*  out  4 x 32     ciphertext block, valid with done
//   cfg_we/index   in   1 / 3      key word write enable and index
//   cfg_data       in   32         key word data
//
// One block enters per cycle. Each round is four registered stages, one per
// word update, and done comes straight from the last stage register. Reset
// clears the key words and every valid bit of the pipeline; nothing waits
// for a clearing pass. The receiver cannot stall, so the pipeline never
// holds and busy stays low. Key words are read directly by all stages and
// may change only while no block is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_like_block_cipher_128 #(
	parameter int unsigned ROUNDS = 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] plain_word_0,
	input  wire logic [31:0] plain_word_1,
	input  wire logic [31:0] plain_word_2,
	input  wire logic [31:0] plain_word_3,
	output logic             done,
	output logic [31:0]      cipher_word_0,
	output logic [31:0]      cipher_word_1,
	output logic [31:0]      cipher_word_2,
	output logic [31:0]      cipher_word_3,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int unsigned NSTAGE = ROUNDS * tlbc_pkg::STEPS_PER_ROUND;

	tlbc_pkg::key_t   key;
	logic             vld [NSTAGE+1];
	tlbc_pkg::block_t blk [NSTAGE+1];

	// Key words
	tlbc_keys u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	// Pipeline never stalls
	assign busy = 1'b0;

	// Pipeline entry
	assign vld[0]    = start && !busy;
	assign blk[0].w0 = plain_word_0;
	assign blk[0].w1 = plain_word_1;
	assign blk[0].w2 = plain_word_2;
	assign blk[0].w3 = plain_word_3;

	// Round stages: four word updates per round
	for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
		localparam tlbc_pkg::step_t STEP =
			tlbc_pkg::step_t'(i % tlbc_pkg::STEPS_PER_ROUND);
		localparam logic [31:0] SUM =
			tlbc_pkg::round_sum(i / tlbc_pkg::STEPS_PER_ROUND);

		tlbc_stage #(
			.STEP (STEP),
			.SUM  (SUM)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld[i]),
			.blk_in  (blk[i]),
			.key     (key),
			.vld_out (vld[i+1]),
			.blk_out (blk[i+1])
		);
	end

	// Result, straight from the last stage register
	assign done          = vld[NSTAGE];
	assign cipher_word_0 = blk[NSTAGE].w0;
	assign cipher_word_1 = blk[NSTAGE].w1;
	assign cipher_word_2 = blk[NSTAGE].w2;
	assign cipher_word_3 = blk[NSTAGE].w3;

	// Every accepted request comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##NSTAGE done)
		else $error("accepted block did not reach the output on time");

	// No result without a request the fixed latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, NSTAGE))
		else $error("result strobe without a matching request");

endmodule

`default_nettype wire

// ----- hw/rtl/tlbc_keys.sv -----
// ----------------------------------------------------------------------------
// tlbc_keys: key register file
// Eight 32-bit key words, written one at a time through the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbc_keys (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [tlbc_pkg::KEY_IDX_W-1:0]    cfg_index,
	input  wire logic [tlbc_pkg::WORD_W-1:0]       cfg_data,
	output tlbc_pkg::key_t                         key
);

	tlbc_pkg::key_t key_q;

	// Key words reset to zero, one word written per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	assign key = key_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tlbc_stage.sv -----
// ----------------------------------------------------------------------------
// tlbc_stage: one word update of a round, registered
// Updates a single word of the block using the key and the fixed round sum;
// the other three words pass through. The valid bit travels with the data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbc_stage #(
	parameter tlbc_pkg::step_t STEP = tlbc_pkg::STEP_W2,
	parameter logic [31:0]     SUM  = 32'h9e37_79b9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             vld_in,
	input  wire tlbc_pkg::block_t blk_in,
	input  wire tlbc_pkg::key_t   key,
	output logic                  vld_out,
	output tlbc_pkg::block_t      blk_out
);

	tlbc_pkg::block_t blk_nxt;
	tlbc_pkg::block_t blk_s1;
	logic             vld_s1;

	// Word update: two adds deep at most
	always_comb begin
		blk_nxt = blk_in;
		unique case (STEP)
			tlbc_pkg::STEP_W2: begin
				blk_nxt.w2 = blk_in.w2 + (key[4] ^ (blk_in.w3 + key[0])
					^ ((SUM + (blk_in.w0 ^ key[1])) << 5));
			end
			tlbc_pkg::STEP_W3: begin
				blk_nxt.w3 = blk_in.w3 + (key[5] ^ (blk_in.w2 + key[1])
					^ ((SUM + (blk_in.w1 ^ key[2])) >> 5));
			end
			tlbc_pkg::STEP_W0: begin
				blk_nxt.w0 = blk_in.w0 + ((key[6] + blk_in.w1)
					^ (((key[2] + SUM) ^ (key[3] + blk_in.w3)) << 4));
			end
			tlbc_pkg::STEP_W1: begin
				blk_nxt.w1 = blk_in.w1 + ((key[7] + blk_in.w0)
					^ (((key[3] + SUM) ^ (key[0] + blk_in.w2)) >> 4));
			end
			default: begin
				blk_nxt = blk_in;
			end
		endcase
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		blk_s1 <= blk_nxt;
	end

	assign vld_out = vld_s1;
	assign blk_out = blk_s1;

endmodule

`default_nettype wire
